FILE: sv/ptp_pkg.sv
`default_nettype none

package ptp_pkg;

  // Field widths of the result items.
  localparam int unsigned GLYPH_W = 16;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned COUNT_W = 16;

  // Glyph total after reset.
  localparam logic [GLYPH_W-1:0] GLYPH_TOTAL_RST = 16'd256;

  // Result item kinds.
  localparam logic ITEM_PAIR    = 1'b0;
  localparam logic ITEM_SUMMARY = 1'b1;

  // Meaning of a byte when it stands in lead position.
  typedef enum logic [2:0] {
    BK_FILL,
    BK_ASCII,
    BK_LEAD2,
    BK_LEAD3,
    BK_LEAD4,
    BK_INVALID
  } byte_kind_e;

  // One classified byte on its way from the front to the back.
  typedef struct packed {
    byte_kind_e  kind;
    logic [6:0]  lead_bits;
    logic [5:0]  cont_bits;
    logic        last;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic               kind;
    logic [GLYPH_W-1:0] glyph;
    logic [CP_W-1:0]    code;
    logic [COUNT_W-1:0] count;
    logic               last;
  } result_t;

  // Up to two result writes in one cycle; the second only with the first.
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t data0;
    result_t data1;
  } res_wr_t;

endpackage

`default_nettype wire

FILE: sv/ptp_fifo.sv
`default_nettype none

module ptp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push0_i,
  input  wire logic                       push1_i,
  input  wire logic [WIDTH-1:0]           data0_i,
  input  wire logic [WIDTH-1:0]           data1_i,
  input  wire logic                       pop_i,
  output logic      [WIDTH-1:0]           rdata_o,
  output logic                            empty_o,
  output logic                            full_o,
  output logic      [$clog2(DEPTH+1)-1:0] free_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nxt;
  logic [CW-1:0]    count_q, count_d;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH-1)) ? '0 : p + AW'(1);
  endfunction

  assign wr_ptr_nxt = ptr_inc(wr_ptr_q);

  // Pointer and fill count update; a second write goes to the slot after the first.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push0_i && push1_i) begin
      wr_ptr_d = ptr_inc(wr_ptr_nxt);
    end else if (push0_i) begin
      wr_ptr_d = wr_ptr_nxt;
    end
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CW'(push0_i) + CW'(push0_i && push1_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_ptr_q] <= data0_i;
    end
    if (push0_i && push1_i) begin
      mem_q[wr_ptr_nxt] <= data1_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign free_o  = CW'(DEPTH) - count_q;

endmodule

`default_nettype wire

FILE: sv/ptp_front.sv
`default_nettype none

module ptp_front (
  input  wire logic        push_i,
  input  wire logic [7:0]  table_byte_i,
  input  wire logic        end_of_data_i,
  input  wire logic        q_full_i,
  output logic             full_o,
  output logic             cmd_push_o,
  output ptp_pkg::cmd_t    cmd_o
);

  import ptp_pkg::*;

  // Classify the byte as a lead byte; the back decides whether it is one.
  always_comb begin
    cmd_o.kind      = BK_INVALID;
    cmd_o.lead_bits = '0;
    cmd_o.cont_bits = table_byte_i[5:0];
    cmd_o.last      = end_of_data_i;
    priority if (table_byte_i == 8'hFF) begin
      cmd_o.kind = BK_FILL;
    end else if (!table_byte_i[7]) begin
      cmd_o.kind      = BK_ASCII;
      cmd_o.lead_bits = table_byte_i[6:0];
    end else if (table_byte_i[7:5] == 3'b110) begin
      cmd_o.kind      = BK_LEAD2;
      cmd_o.lead_bits = {2'b00, table_byte_i[4:0]};
    end else if (table_byte_i[7:4] == 4'b1110) begin
      cmd_o.kind      = BK_LEAD3;
      cmd_o.lead_bits = {3'b000, table_byte_i[3:0]};
    end else if (table_byte_i[7:3] == 5'b11110) begin
      cmd_o.kind      = BK_LEAD4;
      cmd_o.lead_bits = {4'b0000, table_byte_i[2:0]};
    end else begin
      cmd_o.kind = BK_INVALID;
    end
  end

  // A byte transfer happens when push is high and the command queue has room.
  assign full_o     = q_full_i;
  assign cmd_push_o = push_i && !q_full_i;

endmodule

`default_nettype wire

FILE: sv/ptp_back.sv
`default_nettype none

module ptp_back (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [15:0]             cfg_glyph_total_i,
  input  wire logic                    cmd_valid_i,
  input  wire ptp_pkg::cmd_t           cmd_i,
  input  wire logic                    res_room_i,
  output logic                         cmd_take_o,
  output ptp_pkg::res_wr_t             res_wr_o
);

  import ptp_pkg::*;

  logic [GLYPH_W-1:0] total_q;
  logic [1:0]         pend_q, pend_d;
  logic [CP_W-1:0]    part_q, part_d, code;
  logic [GLYPH_W-1:0] glyph_q, glyph_d;
  logic [COUNT_W-1:0] ent_q, ent_d;
  logic               halt_q, halt_d;
  logic               done;

  assign cmd_take_o = cmd_valid_i && res_room_i;

  // Decode one byte against the sequence state.
  always_comb begin
    pend_d  = pend_q;
    part_d  = part_q;
    glyph_d = glyph_q;
    ent_d   = ent_q;
    halt_d  = halt_q;
    done    = 1'b0;
    if (pend_q != 2'd0) begin
      part_d = {part_q[CP_W-7:0], cmd_i.cont_bits};
      pend_d = pend_q - 2'd1;
      done   = (pend_q == 2'd1);
    end else if (!halt_q) begin
      if ((glyph_q >= total_q) || (ent_q >= total_q)) begin
        halt_d = 1'b1;
      end else begin
        unique case (cmd_i.kind)
          BK_FILL:  glyph_d = glyph_q + GLYPH_W'(1);
          BK_ASCII: begin
            part_d = CP_W'(cmd_i.lead_bits);
            done   = 1'b1;
          end
          BK_LEAD2: begin
            part_d = CP_W'(cmd_i.lead_bits);
            pend_d = 2'd1;
          end
          BK_LEAD3: begin
            part_d = CP_W'(cmd_i.lead_bits);
            pend_d = 2'd2;
          end
          BK_LEAD4: begin
            part_d = CP_W'(cmd_i.lead_bits);
            pend_d = 2'd3;
          end
          default: ;
        endcase
      end
    end
    code = part_d;
    if (done) begin
      ent_d  = ent_q + COUNT_W'(1);
      part_d = '0;
    end
  end

  // Build the pair and summary items; when both are written, the pair comes first.
  result_t pair_item, sum_item;

  always_comb begin
    pair_item.kind  = ITEM_PAIR;
    pair_item.glyph = glyph_q;
    pair_item.code  = code;
    pair_item.count = ent_d;
    pair_item.last  = 1'b0;
    sum_item.kind   = ITEM_SUMMARY;
    sum_item.glyph  = glyph_d;
    sum_item.code   = '0;
    sum_item.count  = ent_d;
    sum_item.last   = 1'b1;

    res_wr_o.push0 = cmd_take_o && (done || cmd_i.last);
    res_wr_o.push1 = cmd_take_o && done && cmd_i.last;
    res_wr_o.data0 = done ? pair_item : sum_item;
    res_wr_o.data1 = sum_item;
  end

  // Sequence state; the last byte of a table clears it all.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      part_q  <= '0;
      glyph_q <= '0;
      ent_q   <= '0;
      halt_q  <= 1'b0;
    end else if (cmd_take_o) begin
      if (cmd_i.last) begin
        pend_q  <= '0;
        part_q  <= '0;
        glyph_q <= '0;
        ent_q   <= '0;
        halt_q  <= 1'b0;
      end else begin
        pend_q  <= pend_d;
        part_q  <= part_d;
        glyph_q <= glyph_d;
        ent_q   <= ent_d;
        halt_q  <= halt_d;
      end
    end
  end

  // Glyph total register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= GLYPH_TOTAL_RST;
    end else if (cfg_we_i) begin
      total_q <= cfg_glyph_total_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/psf2_unicode_table_parser.sv
// PSF2 unicode table parser.
//
// Bytes of a font's unicode table enter through a queue-like port: a byte
// transfer happens at a clock edge with push high and full low. Mark the
// final byte of a table with end_of_data_i. Results leave through a second
// queue-like port: the oldest result is shown while empty is low and is
// taken at an edge with pop high. Each decoded codepoint gives a pair item
// with its glyph index; the final byte adds a summary item with the count.
// The user must write the glyph total through cfg_we_i / cfg_glyph_total_i
// only while the block is idle; the block itself does not enforce this.
// Throughput is one byte per cycle while the result queue has at least
// two free slots. A result shows on the result ports once its byte has
// passed through the command queue and been decoded into the result
// queue. A final byte that completes a codepoint writes both of its
// results in the same cycle. Reset empties both queues, clears the
// decoder and sets the glyph total to 256. When the receiver stalls, the
// result queue fills, the decoder stops once fewer than two result slots
// are free, and full rises once the command queue is also filled.
`default_nettype none

module psf2_unicode_table_parser #(
  parameter int unsigned CMD_DEPTH = 4,
  parameter int unsigned RES_DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_glyph_total_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  table_byte_i,
  input  wire logic        end_of_data_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             item_kind_o,
  output logic [15:0]      glyph_number_o,
  output logic [20:0]      code_point_o,
  output logic [15:0]      pair_count_o,
  output logic             last_result_o
);

  import ptp_pkg::*;

  localparam int unsigned RCW = $clog2(RES_DEPTH+1);
  localparam int unsigned CCW = $clog2(CMD_DEPTH+1);

  cmd_t           cmd_in, cmd_out;
  logic           cmd_push, cmd_full, cmd_empty, cmd_take;
  logic [CCW-1:0] cmd_free;
  res_wr_t        res_wr;
  result_t        res_out;
  logic           res_full;
  logic [RCW-1:0] res_free;
  logic           res_room;

  // Front end: classify each byte and queue it.
  ptp_front u_front (
    .push_i        (push),
    .table_byte_i  (table_byte_i),
    .end_of_data_i (end_of_data_i),
    .q_full_i      (cmd_full),
    .full_o        (full),
    .cmd_push_o    (cmd_push),
    .cmd_o         (cmd_in)
  );

  ptp_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (cmd_push),
    .push1_i (1'b0),
    .data0_i (cmd_in),
    .data1_i (cmd_in),
    .pop_i   (cmd_take),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty),
    .full_o  (cmd_full),
    .free_o  (cmd_free)
  );

  // The decoder runs only when at least two result slots are free.
  assign res_room = (res_free >= RCW'(2)) && (cmd_free <= CCW'(CMD_DEPTH));

  ptp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_glyph_total_i (cfg_glyph_total_i),
    .cmd_valid_i       (!cmd_empty),
    .cmd_i             (cmd_out),
    .res_room_i        (res_room),
    .cmd_take_o        (cmd_take),
    .res_wr_o          (res_wr)
  );

  ptp_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (res_wr.push0),
    .push1_i (res_wr.push1),
    .data0_i (res_wr.data0),
    .data1_i (res_wr.data1),
    .pop_i   (pop && !empty),
    .rdata_o (res_out),
    .empty_o (empty),
    .full_o  (res_full),
    .free_o  (res_free)
  );

  // Result ports; a full result queue also shows up as no room to decode.
  assign item_kind_o    = res_out.kind;
  assign glyph_number_o = res_out.glyph;
  assign code_point_o   = res_out.code;
  assign pair_count_o   = res_out.count;
  assign last_result_o  = res_out.last && !(res_full && empty);

endmodule

`default_nettype wire

FILE: sv/ptp_checker.sv
`default_nettype none

module ptp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic        item_kind_o,
  input wire logic [15:0] glyph_number_o,
  input wire logic [20:0] code_point_o,
  input wire logic [15:0] pair_count_o,
  input wire logic        last_result_o
);

  import ptp_pkg::*;

  // A summary ends the run and carries no codepoint.
  a_summary_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && item_kind_o == ITEM_SUMMARY) |-> (last_result_o && code_point_o == '0))
    else $error("summary item malformed");

  // A pair never ends the run.
  a_pair_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && item_kind_o == ITEM_PAIR) |-> !last_result_o)
    else $error("pair item flagged as last");

  // A pair counts itself, so its count is never zero.
  a_pair_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && item_kind_o == ITEM_PAIR) |-> (pair_count_o != '0))
    else $error("pair item with zero count");

  // A waiting result stays put until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(glyph_number_o) && $stable(pair_count_o)))
    else $error("waiting result changed");

endmodule

bind psf2_unicode_table_parser ptp_checker u_ptp_checker (.*);

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ptp_pkg::*;

  // Byte patterns that decide how a byte in lead position is read.
  localparam logic [7:0] FILL_BYTE = 8'hFF;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;
  localparam logic [1:0] CONT_TAG  = 2'b10;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_BYTES  = 170;
  localparam int MAX_REPORTS  = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_glyph_total_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  table_byte_i = '0;
  logic        end_of_data_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        item_kind_o;
  logic [15:0] glyph_number_o;
  logic [20:0] code_point_o;
  logic [15:0] pair_count_o;
  logic        last_result_o;

  // Bytes waiting to be sent, each as {end_of_data, table_byte}.
  logic [8:0] pending_bytes[$];
  result_t    expected_results[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  byte_taken = 1'b0;
  int  fail_count = 0;
  int  cycle_count = 0;

  // Decoder state as the block should hold it.
  logic [1:0]  owed_bytes = '0;
  logic [20:0] code_acc = '0;
  logic [15:0] glyph_at = '0;
  logic [15:0] pairs_made = '0;
  logic        stopped = 1'b0;
  logic [15:0] glyph_limit = GLYPH_TOTAL_RST;

  psf2_unicode_table_parser u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_glyph_total_i(cfg_glyph_total_i),
    .push             (push),
    .full             (full),
    .table_byte_i     (table_byte_i),
    .end_of_data_i    (end_of_data_i),
    .empty            (empty),
    .pop              (pop),
    .item_kind_o      (item_kind_o),
    .glyph_number_o   (glyph_number_o),
    .code_point_o     (code_point_o),
    .pair_count_o     (pair_count_o),
    .last_result_o    (last_result_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Decode one transferred byte and queue the items it should produce.
  task automatic decode_table_byte(input logic [7:0] b, input logic eod);
    logic    finished;
    result_t r;
    finished = 1'b0;
    if (owed_bytes != 2'd0) begin
      code_acc = {code_acc[14:0], b[5:0]};
      owed_bytes = owed_bytes - 2'd1;
      finished = (owed_bytes == 2'd0);
    end else if (!stopped) begin
      if (glyph_at >= glyph_limit || pairs_made >= glyph_limit) begin
        stopped = 1'b1;
      end else if (b == FILL_BYTE) begin
        glyph_at = glyph_at + 16'd1;
      end else if (b[7] == 1'b0) begin
        code_acc = {14'd0, b[6:0]};
        finished = 1'b1;
      end else if (b[7:5] == LEAD2_TAG) begin
        code_acc = {16'd0, b[4:0]};
        owed_bytes = 2'd1;
      end else if (b[7:4] == LEAD3_TAG) begin
        code_acc = {17'd0, b[3:0]};
        owed_bytes = 2'd2;
      end else if (b[7:3] == LEAD4_TAG) begin
        code_acc = {18'd0, b[2:0]};
        owed_bytes = 2'd3;
      end
    end
    if (finished) begin
      pairs_made = pairs_made + 16'd1;
      r.kind  = ITEM_PAIR;
      r.glyph = glyph_at;
      r.code  = code_acc;
      r.count = pairs_made;
      r.last  = 1'b0;
      expected_results.push_back(r);
      code_acc = '0;
    end
    // The final byte closes the table with a summary and a fresh start.
    if (eod) begin
      r.kind  = ITEM_SUMMARY;
      r.glyph = glyph_at;
      r.code  = '0;
      r.count = pairs_made;
      r.last  = 1'b1;
      expected_results.push_back(r);
      owed_bytes = '0;
      code_acc = '0;
      glyph_at = '0;
      pairs_made = '0;
      stopped = 1'b0;
    end
  endtask

  task automatic report_field(input string name, input logic [20:0] exp_v,
                              input logic [20:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Output side: check results first, then predict from the byte transfer.
  always @(posedge clk_i) begin
    result_t exp_r;
    byte_taken = rst_ni && push && !full;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual kind %0b glyph %0h cp %0h",
                     $time, item_kind_o, glyph_number_o, code_point_o);
        end else begin
          exp_r = expected_results.pop_front();
          report_field("item_kind", 21'(exp_r.kind), 21'(item_kind_o));
          report_field("glyph_number", 21'(exp_r.glyph), 21'(glyph_number_o));
          report_field("code_point", exp_r.code, code_point_o);
          report_field("pair_count", 21'(exp_r.count), 21'(pair_count_o));
          report_field("last_result", 21'(exp_r.last), 21'(last_result_o));
        end
      end
      if (cfg_we_i)
        glyph_limit = cfg_glyph_total_i;
      if (byte_taken)
        decode_table_byte(table_byte_i, end_of_data_i);
    end
  end

  // Input side: hold a byte until its transfer, then maybe idle.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!push || byte_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        push <= 1'b1;
        {end_of_data_i, table_byte_i} <= pending_bytes[0];
        pending_bytes.pop_front();
      end else begin
        push <= 1'b0;
      end
    end
    pop <= rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] v, input logic eod);
    pending_bytes.push_back({eod, v});
  endtask

  // One well-formed sequence of random length and content; a continuation
  // byte is now and then replaced by an arbitrary byte.
  task automatic add_code_point();
    int len;
    len = $urandom_range(1, 4);
    case (len)
      1: add_byte({1'b0, 7'($urandom)}, 1'b0);
      2: add_byte({LEAD2_TAG, 5'($urandom)}, 1'b0);
      3: add_byte({LEAD3_TAG, 4'($urandom)}, 1'b0);
      default: add_byte({LEAD4_TAG, 3'($urandom)}, 1'b0);
    endcase
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        add_byte(8'($urandom), 1'b0);
      else
        add_byte({CONT_TAG, 6'($urandom)}, 1'b0);
    end
  endtask

  // One table: glyph separators, sequences and some noise, closed by a
  // final byte that sometimes leaves a sequence unfinished.
  task automatic add_table(input int n_bytes);
    int start_size;
    int pick;
    int last_ix;
    start_size = pending_bytes.size();
    while (pending_bytes.size() - start_size < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 15)
        add_byte(FILL_BYTE, 1'b0);
      else if (pick < 25)
        add_byte(8'($urandom), 1'b0);
      else
        add_code_point();
    end
    if ($urandom_range(0, 4) == 0)
      add_byte({LEAD3_TAG, 4'($urandom)}, 1'b0);
    last_ix = pending_bytes.size() - 1;
    pending_bytes[last_ix] = {1'b1, pending_bytes[last_ix][7:0]};
  endtask

  // Wait until every byte is sent and every result is back, then let any
  // byte that gives no result leave the pipeline.
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || push || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_glyph_total(input logic [15:0] v);
    wait_drained();
    @(negedge clk_i);
    cfg_glyph_total_i = v;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    logic [15:0] totals[RANDOM_PHASES];
    int          phase_start;

    totals[0] = 16'd4;
    totals[1] = 16'd65535;
    totals[2] = 16'd1;
    totals[3] = 16'($urandom_range(2, 16));
    totals[4] = 16'd256;
    totals[5] = 16'd65535;
    totals[6] = 16'($urandom_range(1, 65535));
    totals[7] = 16'd3;
    totals[8] = 16'($urandom_range(8, 64));

    send_idle_pct = 12;
    recv_idle_pct = 56;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table with the reset glyph total: ASCII extremes, each
    // sequence length, the largest codepoint, invalid leads, a glyph
    // separator, continuation bytes that look like 0xFF or leads, and a
    // sequence cut off by the final byte.
    add_byte(8'h00, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(8'hC2, 1'b0);
    add_byte(8'hA9, 1'b0);
    add_byte(8'hE2, 1'b0);
    add_byte(8'h82, 1'b0);
    add_byte(8'hAC, 1'b0);
    add_byte(8'hF7, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hF8, 1'b0);
    add_byte(8'hFE, 1'b0);
    add_byte(FILL_BYTE, 1'b0);
    add_byte(8'hC3, 1'b0);
    add_byte(FILL_BYTE, 1'b0);
    add_byte(8'hE0, 1'b0);
    add_byte(8'hC0, 1'b0);
    add_byte(8'hF0, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(8'hF0, 1'b0);
    add_byte(8'h9F, 1'b1);

    // A single glyph: the byte after the first pair halts decoding for the table.
    write_glyph_total(16'd1);
    add_byte(8'h41, 1'b0);
    add_byte(8'h42, 1'b0);
    add_byte(FILL_BYTE, 1'b1);

    // No glyphs at all: only the summary comes out.
    write_glyph_total(16'd0);
    add_byte(8'h41, 1'b1);

    // Random tables under several glyph totals and idle patterns.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_glyph_total(totals[p]);
      case (p / 3)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_start = pending_bytes.size();
      while (pending_bytes.size() - phase_start < PHASE_BYTES)
        add_table($urandom_range(4, 40));
    end

    wait_drained();
    repeat (12) @(posedge clk_i);
    if (fail_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

FILE: psf2_unicode_table_parser.f
sv/ptp_pkg.sv
sv/ptp_fifo.sv
sv/ptp_front.sv
sv/ptp_back.sv
sv/psf2_unicode_table_parser.sv
sv/ptp_checker.sv
bench/tb_top.sv
